/* design/rhc_pkg.sv */
// ----------------------------------------------------------------------------
// RGB to HSL converter package
// Shared widths, pipeline item types and the restoring divide step used by
// the converter core and its divider pipeline.
// ----------------------------------------------------------------------------
package rhc_pkg;

   localparam int FRAC_BITS          = 16;
   localparam int HUE_FRAC_BITS      = 6;
   localparam int CHAN_W             = 8;
   localparam int SUM_W              = CHAN_W + 1;
   localparam int HUE_W              = 15;
   localparam int FRAC_W             = FRAC_BITS + 1;
   localparam int NUM_W              = 11;
   localparam int DIV_W              = 24;
   localparam int DIV_BITS_PER_STAGE = 4;
   localparam int DIV_STAGES         = DIV_W / DIV_BITS_PER_STAGE;
   localparam int HUE_SECTOR         = 60 * (2 ** HUE_FRAC_BITS);
   // Lightness is sum * 2^FRAC_BITS / 510, i.e. (sum << LIGHT_SHIFT) * 256 / 255.
   localparam int LIGHT_SHIFT        = FRAC_BITS - 9;
   localparam int LIGHT_Z_W          = SUM_W + LIGHT_SHIFT;

   // One long division in flight: the work word shifts the dividend out at
   // the top and the quotient in at the bottom.
   typedef struct packed {
      logic [DIV_W-1:0]  work;
      logic [CHAN_W-1:0] rem;
      logic [CHAN_W-1:0] divisor;
   } div_lane_type;

   typedef struct packed {
      div_lane_type      sat;
      div_lane_type      hue;
      logic              grey;
      logic [FRAC_W-1:0] lightness;
      logic [CHAN_W-1:0] opacity;
   } div_item_type;

   function automatic div_lane_type div_step(div_lane_type lane);
      logic [CHAN_W:0] shifted;
      logic            fits;
      div_lane_type    res;
      shifted = {lane.rem, lane.work[DIV_W-1]};
      fits    = (shifted >= {1'b0, lane.divisor});
      res     = lane;
      if (fits) begin
         res.rem = CHAN_W'(shifted - {1'b0, lane.divisor});
      end else begin
         res.rem = shifted[CHAN_W-1:0];
      end
      res.work = {lane.work[DIV_W-2:0], fits};
      return res;
   endfunction

endpackage

/* design/rhc_div_pipe.sv */
// ----------------------------------------------------------------------------
// RGB to HSL divider pipeline
// Two restoring dividers side by side, a few quotient bits per register
// stage, with a valid bit per stage and a per-stage ready chain.
// ----------------------------------------------------------------------------
module rhc_div_pipe
   import rhc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_stall,
   input  div_item_type in_item,
   output logic         out_valid,
   input  logic         out_stall,
   output div_item_type out_item
);

   logic         valid_ff  [DIV_STAGES];
   logic         valid_in  [DIV_STAGES];
   logic         ready     [DIV_STAGES];
   logic         src_valid [DIV_STAGES];
   div_item_type src_item  [DIV_STAGES];
   div_item_type item_ff   [DIV_STAGES];
   div_item_type item_in   [DIV_STAGES];

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      if (s == 0) begin : g_first
         assign src_valid[s] = in_valid;
         assign src_item[s]  = in_item;
      end else begin : g_next
         assign src_valid[s] = valid_ff[s-1];
         assign src_item[s]  = item_ff[s-1];
      end

      // A stage may take a new item when it is empty or its item moves on.
      if (s == DIV_STAGES - 1) begin : g_last
         assign ready[s] = !valid_ff[s] || !out_stall;
      end else begin : g_mid
         assign ready[s] = !valid_ff[s] || ready[s+1];
      end

      assign valid_in[s] = ready[s] ? src_valid[s] : valid_ff[s];

      always_comb begin
         item_in[s] = src_item[s];
         for (int k = 0; k < DIV_BITS_PER_STAGE; k++) begin
            item_in[s].sat = div_step(item_in[s].sat);
            item_in[s].hue = div_step(item_in[s].hue);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= valid_in[s];
         end
         if (ready[s] && src_valid[s]) begin
            item_ff[s] <= item_in[s];
         end
      end
   end

   assign in_stall  = !ready[0];
   assign out_valid = valid_ff[DIV_STAGES-1];
   assign out_item  = item_ff[DIV_STAGES-1];

endmodule

/* design/rgb_to_hsl_converter_core.sv */
// ----------------------------------------------------------------------------
// RGB to HSL converter core
// Converts one 8-bit RGBA pixel per clock, while no stall holds the flow, into
// hue, saturation, lightness and the unchanged alpha.
// ----------------------------------------------------------------------------
// Usage:
// Pixels enter on the req_ channel and results leave on the rsp_ channel,
// one result per pixel, in order. An item moves when valid is high and
// stall is low on its channel.
// From acceptance to rsp_valid an item passes the front-end register (its
// dividends, divisors, grey flag and lightness), which loads at the
// accepting edge, then six divider stages of four quotient bits each and
// one output register.
// Throughput is one pixel per clock while nothing stalls; the two divisions
// are pipelined, so a new pixel may enter every cycle unless a stall holds it.
// Reset clears every valid bit; the block takes a pixel in the first cycle
// after reset. When the receiver stalls, results stay in the output
// register and items close up behind it; req_stall rises only once every
// stage is full.
// ----------------------------------------------------------------------------
module rgb_to_hsl_converter_core
   import rhc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [CHAN_W-1:0] req_red,
   input  logic [CHAN_W-1:0] req_green,
   input  logic [CHAN_W-1:0] req_blue,
   input  logic [CHAN_W-1:0] req_opacity,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [HUE_W-1:0]  rsp_hue,
   output logic [FRAC_W-1:0] rsp_saturation,
   output logic [FRAC_W-1:0] rsp_lightness,
   output logic [CHAN_W-1:0] rsp_opacity_out
);

   logic [CHAN_W-1:0]    mx;
   logic [CHAN_W-1:0]    mn;
   logic [CHAN_W-1:0]    diff;
   logic [SUM_W-1:0]     sum;
   logic [CHAN_W-1:0]    den;
   logic [NUM_W-1:0]     num;
   logic [LIGHT_Z_W-1:0] light_z;
   logic [FRAC_W-1:0]    light_q;
   div_item_type         fe_item_in;
   div_item_type         fe_item_ff;
   logic                 fe_valid_ff;
   logic                 fe_valid_in;
   logic                 fe_ready;
   logic                 div_in_stall;
   logic                 div_out_valid;
   div_item_type         div_out_item;
   logic                 out_ready;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [HUE_W-1:0]     rsp_hue_ff;
   logic [HUE_W-1:0]     rsp_hue_in;
   logic [FRAC_W-1:0]    rsp_sat_ff;
   logic [FRAC_W-1:0]    rsp_sat_in;
   logic [FRAC_W-1:0]    rsp_light_ff;
   logic [CHAN_W-1:0]    rsp_opacity_ff;

   // Front end: extremes, hue numerator scaled by d, divisors, lightness.
   always_comb begin
      mx = req_red;
      if (req_green > mx) mx = req_green;
      if (req_blue > mx)  mx = req_blue;
      mn = req_red;
      if (req_green < mn) mn = req_green;
      if (req_blue < mn)  mn = req_blue;
      diff = mx - mn;
      sum  = SUM_W'(mx) + SUM_W'(mn);
      if (sum < SUM_W'(255)) begin
         den = sum[CHAN_W-1:0];
      end else begin
         den = CHAN_W'(SUM_W'(510) - sum);
      end

      // The numerator is always in range, so modular arithmetic is exact.
      if (mx == req_red) begin
         num = NUM_W'(req_green) - NUM_W'(req_blue);
         if (req_green < req_blue) num = num + NUM_W'(6 * diff);
      end else if (mx == req_green) begin
         num = NUM_W'(req_blue) - NUM_W'(req_red) + NUM_W'(2 * diff);
      end else begin
         num = NUM_W'(req_red) - NUM_W'(req_green) + NUM_W'(4 * diff);
      end

      // z / 255 equals (z + 1 + (z >> 8)) >> 8 for every z up to 256 * 255.
      light_z = LIGHT_Z_W'(sum) << LIGHT_SHIFT;
      light_q = FRAC_W'((FRAC_W'(light_z) + FRAC_W'(1) + FRAC_W'(light_z >> 8)) >> 8);

      fe_item_in.sat.work    = DIV_W'(diff) << FRAC_BITS;
      fe_item_in.sat.rem     = '0;
      fe_item_in.sat.divisor = den;
      fe_item_in.hue.work    = DIV_W'(DIV_W'(num) * DIV_W'(HUE_SECTOR));
      fe_item_in.hue.rem     = '0;
      fe_item_in.hue.divisor = diff;
      fe_item_in.grey        = (diff == '0);
      fe_item_in.lightness   = FRAC_W'(light_z) + light_q;
      fe_item_in.opacity     = req_opacity;
   end

   assign fe_ready    = !fe_valid_ff || !div_in_stall;
   assign fe_valid_in = fe_ready ? req_valid : fe_valid_ff;
   assign req_stall   = !fe_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         fe_valid_ff <= 1'b0;
      end else begin
         fe_valid_ff <= fe_valid_in;
      end
      if (fe_ready && req_valid) begin
         fe_item_ff <= fe_item_in;
      end
   end

   rhc_div_pipe u_div_pipe (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fe_valid_ff),
      .in_stall  (div_in_stall),
      .in_item   (fe_item_ff),
      .out_valid (div_out_valid),
      .out_stall (!out_ready),
      .out_item  (div_out_item)
   );

   // Output register: a grey pixel has neither hue nor saturation.
   assign out_ready    = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = out_ready ? div_out_valid : rsp_valid_ff;
   assign rsp_hue_in   = div_out_item.grey ? '0 : div_out_item.hue.work[HUE_W-1:0];
   assign rsp_sat_in   = div_out_item.grey ? '0 : div_out_item.sat.work[FRAC_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (out_ready && div_out_valid) begin
         rsp_hue_ff     <= rsp_hue_in;
         rsp_sat_ff     <= rsp_sat_in;
         rsp_light_ff   <= div_out_item.lightness;
         rsp_opacity_ff <= div_out_item.opacity;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hue         = rsp_hue_ff;
   assign rsp_saturation  = rsp_sat_ff;
   assign rsp_lightness   = rsp_light_ff;
   assign rsp_opacity_out = rsp_opacity_ff;

endmodule
